// ----- src/pira_pkg.sv -----
// shared types and codes for the positional insert/remove list
`default_nettype none

package pira_pkg;

   typedef enum logic [3:0] {
      ACT_APPEND    = 4'd0,
      ACT_INS_AT    = 4'd1,
      ACT_INS_FRONT = 4'd2,
      ACT_REM_BACK  = 4'd3,
      ACT_REM_AT    = 4'd4,
      ACT_REM_FRONT = 4'd5,
      ACT_READ      = 4'd6,
      ACT_WRITE     = 4'd7,
      ACT_FIND      = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BOUNDS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PUT,
      S_PUT_ADD,
      S_INS_TEST,
      S_INS_MOVE,
      S_RD_TAKE,
      S_RD_WAIT,
      S_RM_TAKE,
      S_RM_WAIT,
      S_RM_TEST,
      S_RM_MOVE,
      S_FIND_TEST,
      S_FIND_CMP,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_COUNT_M1,
      IDX_POS,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic       load;
      logic       chk;
      logic       miss;
      logic       take_found;
      logic       take_data;
      logic       emit;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_word;
      idx_op_type idx_op;
      cnt_op_type cnt_op;
   } cmd_type;

   typedef struct packed {
      action_type act;
      logic       chk_fail;
      logic       idx_gt_pos;
      logic       idx_next_lt_n;
      logic       idx_lt_n;
      logic       match;
   } sts_type;

endpackage

`default_nettype wire

// ----- src/pira_dp.sv -----
// datapath: element memory, count, index, check logic and result registers
`default_nettype none

module pira_dp #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pira_pkg::cmd_type   cmd,
   output pira_pkg::sts_type        sts,
   input  wire logic [3:0]          req_action,
   input  wire logic [5:0]          req_position_in,
   input  wire logic signed [31:0]  req_data_in,
   output logic                     rsp_strobe,
   output logic signed [31:0]       rsp_data_out,
   output logic [5:0]               rsp_found_position,
   output logic [2:0]               rsp_status,
   output logic [6:0]               rsp_count_out
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;

   logic signed [WORD_BITS-1:0] mem [DEPTH];

   pira_pkg::action_type        act_ff, act_in;
   logic [CMPW-1:0]             pos_ff, pos_in;
   logic [WORD_BITS-1:0]        word_ff, word_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic signed [WORD_BITS-1:0] rdata_ff;
   logic signed [31:0]          data_ff, data_in;
   logic [5:0]                  found_ff, found_in;
   pira_pkg::status_type        status_ff, status_in;
   logic                        strobe_ff, strobe_in;

   pira_pkg::action_type        req_act;
   pira_pkg::status_type        chk_status;
   logic                        full;
   logic                        empty;
   logic                        pos_ge;
   logic [CW-1:0]               rd_addr;
   logic [CW-1:0]               idx_p1;
   logic [CW-1:0]               idx_m1;

   assign req_act = pira_pkg::action_type'(req_action);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_ge  = (pos_ff >= CMPW'(count_ff));
   assign idx_p1  = idx_ff + CW'(1);
   assign idx_m1  = idx_ff - CW'(1);

   always_comb begin
      case (act_ff)
         pira_pkg::ACT_APPEND:    chk_status = full ? pira_pkg::ST_FULL : pira_pkg::ST_OK;
         pira_pkg::ACT_INS_AT:    chk_status = pos_ge ? pira_pkg::ST_BOUNDS :
                                               full ? pira_pkg::ST_FULL : pira_pkg::ST_OK;
         pira_pkg::ACT_INS_FRONT: chk_status = full ? pira_pkg::ST_FULL : pira_pkg::ST_OK;
         pira_pkg::ACT_REM_BACK:  chk_status = empty ? pira_pkg::ST_EMPTY : pira_pkg::ST_OK;
         pira_pkg::ACT_REM_AT:    chk_status = pos_ge ? pira_pkg::ST_BOUNDS : pira_pkg::ST_OK;
         pira_pkg::ACT_REM_FRONT: chk_status = empty ? pira_pkg::ST_EMPTY : pira_pkg::ST_OK;
         pira_pkg::ACT_READ:      chk_status = pos_ge ? pira_pkg::ST_BOUNDS : pira_pkg::ST_OK;
         pira_pkg::ACT_WRITE:     chk_status = pos_ge ? pira_pkg::ST_BOUNDS : pira_pkg::ST_OK;
         default:                 chk_status = pira_pkg::ST_OK;
      endcase
   end

   always_comb begin
      sts.act           = act_ff;
      sts.chk_fail      = (chk_status != pira_pkg::ST_OK);
      sts.idx_gt_pos    = (CMPW'(idx_ff) > pos_ff);
      sts.idx_next_lt_n = (idx_p1 < count_ff);
      sts.idx_lt_n      = (idx_ff < count_ff);
      sts.match         = (rdata_ff == word_ff);
   end

   // next values
   always_comb begin
      act_in    = act_ff;
      pos_in    = pos_ff;
      word_in   = word_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      data_in   = data_ff;
      found_in  = found_ff;
      status_in = status_ff;
      strobe_in = cmd.emit;

      if (cmd.load) begin
         act_in  = req_act;
         word_in = WORD_BITS'(req_data_in);
         if (req_act == pira_pkg::ACT_INS_FRONT || req_act == pira_pkg::ACT_REM_FRONT) begin
            pos_in = '0;
         end else begin
            pos_in = CMPW'(req_position_in);
         end
      end

      if (cmd.chk) begin
         status_in = chk_status;
         data_in   = '0;
         found_in  = '0;
      end
      if (cmd.miss) begin
         status_in = pira_pkg::ST_NOTFOUND;
      end
      if (cmd.take_found) begin
         status_in = pira_pkg::ST_OK;
         found_in  = 6'(idx_ff);
      end
      if (cmd.take_data) begin
         data_in = 32'(rdata_ff);
      end

      case (cmd.idx_op)
         pira_pkg::IDX_COUNT:    idx_in = count_ff;
         pira_pkg::IDX_COUNT_M1: idx_in = count_ff - CW'(1);
         pira_pkg::IDX_POS:      idx_in = pos_ff[CW-1:0];
         pira_pkg::IDX_ZERO:     idx_in = '0;
         pira_pkg::IDX_INC:      idx_in = idx_p1;
         pira_pkg::IDX_DEC:      idx_in = idx_m1;
         default:                idx_in = idx_ff;
      endcase

      case (cmd.cnt_op)
         pira_pkg::CNT_INC: count_in = count_ff + CW'(1);
         pira_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:           count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         pira_pkg::RD_PREV: rd_addr = idx_m1;
         pira_pkg::RD_NEXT: rd_addr = idx_p1;
         default:           rd_addr = idx_ff;
      endcase
   end

   // element memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[AW-1:0]] <= cmd.wr_word ? word_ff : rdata_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      word_ff   <= word_in;
      idx_ff    <= idx_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_data_out       = data_ff;
   assign rsp_found_position = found_ff;
   assign rsp_status         = status_ff;
   assign rsp_count_out      = 7'(count_ff);

endmodule

`default_nettype wire

// ----- src/pira_ctrl.sv -----
// controller state machine sequencing each item over the datapath
`default_nettype none

module pira_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pira_pkg::sts_type sts,
   output pira_pkg::cmd_type      cmd,
   output logic                   busy
);

   pira_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pira_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pira_pkg::S_IDLE: begin
            if (start) state_in = pira_pkg::S_CHECK;
         end
         pira_pkg::S_CHECK: begin
            if (sts.chk_fail) begin
               state_in = pira_pkg::S_EMIT;
            end else begin
               case (sts.act)
                  pira_pkg::ACT_APPEND:    state_in = pira_pkg::S_PUT_ADD;
                  pira_pkg::ACT_INS_AT:    state_in = pira_pkg::S_INS_TEST;
                  pira_pkg::ACT_INS_FRONT: state_in = pira_pkg::S_INS_TEST;
                  pira_pkg::ACT_REM_BACK:  state_in = pira_pkg::S_RD_TAKE;
                  pira_pkg::ACT_READ:      state_in = pira_pkg::S_RD_TAKE;
                  pira_pkg::ACT_REM_AT:    state_in = pira_pkg::S_RM_TAKE;
                  pira_pkg::ACT_REM_FRONT: state_in = pira_pkg::S_RM_TAKE;
                  pira_pkg::ACT_WRITE:     state_in = pira_pkg::S_PUT;
                  pira_pkg::ACT_FIND:      state_in = pira_pkg::S_FIND_TEST;
                  default:                 state_in = pira_pkg::S_EMIT;
               endcase
            end
         end
         pira_pkg::S_PUT:     state_in = pira_pkg::S_EMIT;
         pira_pkg::S_PUT_ADD: state_in = pira_pkg::S_EMIT;
         pira_pkg::S_INS_TEST: begin
            state_in = sts.idx_gt_pos ? pira_pkg::S_INS_MOVE : pira_pkg::S_PUT_ADD;
         end
         pira_pkg::S_INS_MOVE: state_in = pira_pkg::S_INS_TEST;
         pira_pkg::S_RD_TAKE:  state_in = pira_pkg::S_RD_WAIT;
         pira_pkg::S_RD_WAIT:  state_in = pira_pkg::S_EMIT;
         pira_pkg::S_RM_TAKE:  state_in = pira_pkg::S_RM_WAIT;
         pira_pkg::S_RM_WAIT:  state_in = pira_pkg::S_RM_TEST;
         pira_pkg::S_RM_TEST: begin
            state_in = sts.idx_next_lt_n ? pira_pkg::S_RM_MOVE : pira_pkg::S_EMIT;
         end
         pira_pkg::S_RM_MOVE: state_in = pira_pkg::S_RM_TEST;
         pira_pkg::S_FIND_TEST: begin
            state_in = sts.idx_lt_n ? pira_pkg::S_FIND_CMP : pira_pkg::S_EMIT;
         end
         pira_pkg::S_FIND_CMP: begin
            state_in = sts.match ? pira_pkg::S_EMIT : pira_pkg::S_FIND_TEST;
         end
         pira_pkg::S_EMIT: state_in = pira_pkg::S_IDLE;
         default:          state_in = pira_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         pira_pkg::S_IDLE: begin
            cmd.load = start;
         end
         pira_pkg::S_CHECK: begin
            cmd.chk = 1'b1;
            case (sts.act)
               pira_pkg::ACT_APPEND:    cmd.idx_op = pira_pkg::IDX_COUNT;
               pira_pkg::ACT_INS_AT:    cmd.idx_op = pira_pkg::IDX_COUNT;
               pira_pkg::ACT_INS_FRONT: cmd.idx_op = pira_pkg::IDX_COUNT;
               pira_pkg::ACT_REM_BACK:  cmd.idx_op = pira_pkg::IDX_COUNT_M1;
               pira_pkg::ACT_FIND:      cmd.idx_op = pira_pkg::IDX_ZERO;
               default:                 cmd.idx_op = pira_pkg::IDX_POS;
            endcase
         end
         pira_pkg::S_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_word = 1'b1;
         end
         pira_pkg::S_PUT_ADD: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_word = 1'b1;
            cmd.cnt_op  = pira_pkg::CNT_INC;
         end
         pira_pkg::S_INS_TEST: begin
            if (sts.idx_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pira_pkg::RD_PREV;
            end
         end
         pira_pkg::S_INS_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = pira_pkg::IDX_DEC;
         end
         pira_pkg::S_RD_TAKE: begin
            cmd.rd_en = 1'b1;
         end
         pira_pkg::S_RD_WAIT: begin
            cmd.take_data = 1'b1;
            if (sts.act == pira_pkg::ACT_REM_BACK) cmd.cnt_op = pira_pkg::CNT_DEC;
         end
         pira_pkg::S_RM_TAKE: begin
            cmd.rd_en = 1'b1;
         end
         pira_pkg::S_RM_WAIT: begin
            cmd.take_data = 1'b1;
         end
         pira_pkg::S_RM_TEST: begin
            if (sts.idx_next_lt_n) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = pira_pkg::RD_NEXT;
            end else begin
               cmd.cnt_op = pira_pkg::CNT_DEC;
            end
         end
         pira_pkg::S_RM_MOVE: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = pira_pkg::IDX_INC;
         end
         pira_pkg::S_FIND_TEST: begin
            if (sts.idx_lt_n) begin
               cmd.rd_en = 1'b1;
            end else begin
               cmd.miss = 1'b1;
            end
         end
         pira_pkg::S_FIND_CMP: begin
            if (sts.match) begin
               cmd.take_found = 1'b1;
            end else begin
               cmd.idx_op = pira_pkg::IDX_INC;
            end
         end
         pira_pkg::S_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != pira_pkg::S_IDLE);

endmodule

`default_nettype wire

// ----- src/positional_insert_remove_array.sv -----
// top level: ordered list with positional insert, remove, read, write and find
// busy stays high from acceptance of an item until its result; errors and unused actions
// leave the list as it is, insert and remove at or at the front shift the entries between
// position and count one at a time, and find compares entries from the front until a match or the end
// the strobe follows the last busy cycle, a new item may start then
// synchronous reset empties the list; entries are not cleared
`default_nettype none

module positional_insert_remove_array #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [3:0]         req_action,
   input  wire logic [5:0]         req_position_in,
   input  wire logic signed [31:0] req_data_in,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_data_out,
   output logic [5:0]              rsp_found_position,
   output logic [2:0]              rsp_status,
   output logic [6:0]              rsp_count_out
);

   pira_pkg::cmd_type cmd;
   pira_pkg::sts_type sts;

   pira_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   pira_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_position_in    (req_position_in),
      .req_data_in        (req_data_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_count_out      (rsp_count_out)
   );

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != pira_pkg::ST_OK) |-> (rsp_data_out == '0))
      else $error("failed action returned data");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_count_out == $past(rsp_count_out)
                      || rsp_count_out == $past(rsp_count_out) + 7'd1
                      || rsp_count_out == $past(rsp_count_out) - 7'd1))
      else $error("count moved by more than one");

endmodule

`default_nettype wire
